// ===== hdl/tv_flicker_light_effect_assert.svh =====
// Assertion helpers for the flicker sequencer.
`ifndef TV_FLICKER_LIGHT_EFFECT_ASSERT_SVH
`define TV_FLICKER_LIGHT_EFFECT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TVFL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TVFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tvfl_pkg.sv =====
package tvfl_pkg;

  localparam int unsigned LEVEL_BITS   = 16;
  localparam int unsigned WAIT_BITS    = 13;
  localparam int unsigned STEP_BITS    = 12;
  localparam int unsigned TENTH_BITS   = 9;
  localparam int unsigned PCT_BITS     = 7;
  localparam int unsigned PCT_MAX      = 100;
  localparam int unsigned BRIGHT_SCALE = 255 * 256 / 100;
  localparam int unsigned PAUSE_BASE   = 5000;
  localparam int unsigned PAUSE_SLOPE  = 47;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_SPEED      = 2'd1,
    REG_REPEAT     = 2'd2
  } tvfl_reg_t;

  // One tick item
  typedef struct packed {
    logic [9:0] elapsed_ms;
    logic       restart;
  } tvfl_in_t;

  // One result item
  typedef struct packed {
    logic [LEVEL_BITS-1:0] level_warm;
    logic [LEVEL_BITS-1:0] level_cool;
    logic [LEVEL_BITS-1:0] level_red;
    logic [LEVEL_BITS-1:0] level_green;
    logic [LEVEL_BITS-1:0] level_blue;
    logic                  changed;
    logic [2:0]            phase_now;
  } tvfl_out_t;

  // Settings held in ready-to-use form for the sequencer
  typedef struct packed {
    logic [LEVEL_BITS-1:0] bv_half;
    logic [LEVEL_BITS-1:0] l1_init;
    logic [LEVEL_BITS-1:0] l2_init;
    logic [STEP_BITS-1:0]  step;
    logic [WAIT_BITS-1:0]  pause;
    logic [TENTH_BITS-1:0] pause_tenth;
    logic                  halt;
    logic                  repeat_on;
  } tvfl_cfg_t;

endpackage

// ===== hdl/tvfl_cfg.sv =====
module tvfl_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tvfl_pkg::PCT_BITS-1:0]   cfg_data,
  output tvfl_pkg::tvfl_cfg_t             cfg
);
  import tvfl_pkg::*;

  // Reciprocal multipliers folded with the brightness scale
  localparam longint unsigned HALF_MUL  = BRIGHT_SCALE / 2;
  localparam longint unsigned L1_MUL    = 2 * BRIGHT_SCALE * 87382;   // 2bv/3, shift 18
  localparam longint unsigned L2_MUL    = 4 * BRIGHT_SCALE * 209716;  // 4bv/5, shift 20
  localparam longint unsigned STEP_MUL  = BRIGHT_SCALE * 83887;       // bv/100, shift 23
  localparam longint unsigned TENTH_MUL = 6554;                       // x/10, shift 16

  logic [PCT_BITS-1:0]   bright_src;
  logic [PCT_BITS-1:0]   speed_src;
  logic [PCT_BITS-1:0]   b_clamp;
  logic [39:0]           p_l1;
  logic [39:0]           p_l2;
  logic [39:0]           p_step;
  logic [9:0]            step_q;
  logic [LEVEL_BITS-1:0] half_calc;
  logic [STEP_BITS-1:0]  step_calc;
  logic [WAIT_BITS-1:0]  pause_calc;
  logic [25:0]           p_tenth;
  logic                  halt_calc;

  // Take reset values through the same arithmetic as written values
  assign bright_src = rst ? PCT_BITS'(PCT_MAX) : cfg_data;
  assign speed_src  = rst ? PCT_BITS'(PCT_MAX) : cfg_data;

  // Brightness derived levels
  always_comb begin
    b_clamp   = (bright_src > PCT_BITS'(PCT_MAX)) ? PCT_BITS'(PCT_MAX) : bright_src;
    half_calc = LEVEL_BITS'(b_clamp) * LEVEL_BITS'(HALF_MUL);
    p_l1      = 40'(b_clamp) * 40'(L1_MUL);
    p_l2      = 40'(b_clamp) * 40'(L2_MUL);
    p_step    = 40'(b_clamp) * 40'(STEP_MUL);
    step_q    = p_step[32:23];
    step_calc = STEP_BITS'({step_q, 2'b00}) + STEP_BITS'(step_q);
  end

  // Speed derived pauses
  always_comb begin
    pause_calc = WAIT_BITS'(PAUSE_BASE) - WAIT_BITS'(speed_src) * WAIT_BITS'(PAUSE_SLOPE);
    p_tenth    = 26'(pause_calc) * 26'(TENTH_MUL);
    halt_calc  = speed_src > PCT_BITS'(PCT_MAX);
  end

  // Hold settings; load on reset or on a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bv_half     <= half_calc;
      cfg.l1_init     <= p_l1[33:18];
      cfg.l2_init     <= p_l2[35:20];
      cfg.step        <= step_calc;
      cfg.pause       <= pause_calc;
      cfg.pause_tenth <= p_tenth[24:16];
      cfg.halt        <= halt_calc;
      cfg.repeat_on   <= 1'b1;
    end else if (cfg_we) begin
      case (tvfl_reg_t'(cfg_index))
        REG_BRIGHTNESS: begin
          cfg.bv_half <= half_calc;
          cfg.l1_init <= p_l1[33:18];
          cfg.l2_init <= p_l2[35:20];
          cfg.step    <= step_calc;
        end
        REG_SPEED: begin
          cfg.pause       <= pause_calc;
          cfg.pause_tenth <= p_tenth[24:16];
          cfg.halt        <= halt_calc;
        end
        REG_REPEAT: begin
          cfg.repeat_on <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/tvfl_core.sv =====
module tvfl_core #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step_en,
  input  tvfl_pkg::tvfl_in_t   item,
  input  tvfl_pkg::tvfl_cfg_t  cfg,
  output tvfl_pkg::tvfl_out_t  result
);
  import tvfl_pkg::*;

  typedef enum logic [2:0] {
    PH_LOAD     = 3'd0,
    PH_RB_FLASH = 3'd1,
    PH_RB_DECAY = 3'd2,
    PH_WC_FLASH = 3'd3,
    PH_WC_DECAY = 3'd4,
    PH_BC_FLASH = 3'd5,
    PH_BC_DECAY = 3'd6
  } ph_t;

  typedef logic [LEVEL_BITS-1:0] lvl_t;

  // x/3 for 16-bit x
  function automatic lvl_t div3(input lvl_t x);
    logic [32:0] p;
    p = 33'(x) * 33'(43691);
    return p[32:17];
  endfunction

  // x/5 for 16-bit x
  function automatic lvl_t div5(input lvl_t x);
    logic [33:0] p;
    p = 34'(x) * 34'(52429);
    return p[33:18];
  endfunction

  // 3x/10 for 16-bit x: 3x times the reciprocal of ten, shift 21
  function automatic lvl_t tri_tenth(input lvl_t x);
    logic [17:0] t;
    logic [36:0] p;
    t = 18'({x, 1'b0}) + 18'(x);
    p = 37'(t) * 37'(209716);
    return p[36:21];
  endfunction

  // x/2 + x, kept to 16 bits
  function automatic lvl_t one_half(input lvl_t x);
    logic [LEVEL_BITS:0] s;
    s = {2'b00, x[LEVEL_BITS-1:1]} + {1'b0, x};
    return s[LEVEL_BITS-1:0];
  endfunction

  ph_t                  phase, phase_next;
  logic [TIMER_BITS-1:0] now_ms, now_next;
  logic [TIMER_BITS-1:0] mark_ms, mark_next;
  logic [TIMER_BITS-1:0] since;
  logic [WAIT_BITS-1:0]  wait_ms, wait_next;
  lvl_t                  lvl0, lvl1, lvl2;
  lvl_t                  lvl0_next, lvl1_next, lvl2_next;
  lvl_t                  ch_warm, ch_cool, ch_red, ch_green, ch_blue;
  lvl_t                  warm_next, cool_next, red_next, green_next, blue_next;
  lvl_t                  step_w;
  logic                  waiting;
  tvfl_out_t             result_next;

  assign step_w = LEVEL_BITS'(cfg.step);

  // Run one phase of the sequencer
  always_comb begin
    now_next   = now_ms + TIMER_BITS'(item.elapsed_ms);
    phase_next = item.restart ? PH_LOAD : phase;
    mark_next  = mark_ms;
    wait_next  = wait_ms;
    lvl0_next  = lvl0;
    lvl1_next  = lvl1;
    lvl2_next  = lvl2;
    warm_next  = ch_warm;
    cool_next  = ch_cool;
    red_next   = ch_red;
    green_next = ch_green;
    blue_next  = ch_blue;
    since      = now_next - mark_ms;
    waiting    = since < {{(TIMER_BITS-WAIT_BITS){1'b0}}, wait_ms};

    if (!cfg.halt) begin
      case (phase_next)
        PH_LOAD: begin
          warm_next  = '0;
          cool_next  = '0;
          red_next   = '0;
          green_next = '0;
          blue_next  = '0;
          lvl0_next  = cfg.bv_half;
          lvl1_next  = cfg.l1_init;
          lvl2_next  = cfg.bv_half;
          wait_next  = '0;
          phase_next = PH_RB_FLASH;
        end
        PH_RB_FLASH: begin
          red_next   = lvl0 >> 1;
          cool_next  = one_half(lvl0);
          lvl0_next  = tri_tenth(lvl0);
          wait_next  = cfg.pause;
          mark_next  = now_next;
          phase_next = PH_RB_DECAY;
        end
        PH_RB_DECAY: begin
          if (!waiting) begin
            if (step_w < lvl0) begin
              red_next  = lvl0 >> 1;
              blue_next = lvl0;
              cool_next = lvl0 >> 1;
              lvl0_next = lvl0 - step_w;
              wait_next = WAIT_BITS'(cfg.pause_tenth);
              mark_next = now_next;
            end else begin
              wait_next  = cfg.pause;
              red_next   = '0;
              blue_next  = '0;
              phase_next = PH_WC_FLASH;
            end
          end
        end
        PH_WC_FLASH: begin
          warm_next  = div3(lvl1);
          cool_next  = lvl1;
          lvl1_next  = div5(lvl1);
          mark_next  = now_next;
          phase_next = PH_WC_DECAY;
        end
        PH_WC_DECAY: begin
          if (!waiting) begin
            if (step_w < lvl1) begin
              warm_next = div3(lvl1);
              cool_next = lvl1;
              lvl1_next = lvl1 - step_w;
              wait_next = WAIT_BITS'(cfg.pause_tenth);
              mark_next = now_next;
            end else begin
              wait_next  = cfg.pause;
              warm_next  = '0;
              cool_next  = '0;
              phase_next = PH_BC_FLASH;
            end
          end
        end
        PH_BC_FLASH: begin
          blue_next  = lvl2 >> 2;
          cool_next  = lvl2 >> 1;
          lvl2_next  = div5(lvl2);
          mark_next  = now_next;
          phase_next = PH_BC_DECAY;
        end
        PH_BC_DECAY: begin
          if (!waiting) begin
            if (step_w < lvl2) begin
              blue_next = lvl2 >> 1;
              cool_next = one_half(lvl2);
              lvl2_next = lvl2 - step_w;
              wait_next = WAIT_BITS'(cfg.pause_tenth);
              mark_next = now_next;
            end else begin
              wait_next  = cfg.pause;
              blue_next  = '0;
              green_next = '0;
              lvl0_next  = cfg.l1_init;
              lvl1_next  = cfg.l1_init;
              lvl2_next  = cfg.l2_init;
              if (cfg.repeat_on) begin
                phase_next = PH_RB_FLASH;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    result_next.level_warm  = warm_next;
    result_next.level_cool  = cool_next;
    result_next.level_red   = red_next;
    result_next.level_green = green_next;
    result_next.level_blue  = blue_next;
    result_next.changed     = (warm_next != ch_warm) || (cool_next != ch_cool) ||
                              (red_next != ch_red) || (green_next != ch_green) ||
                              (blue_next != ch_blue);
    result_next.phase_now   = phase_next;
  end

  // Hold sequencer state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOAD;
      now_ms   <= '0;
      mark_ms  <= '0;
      wait_ms  <= '0;
      lvl0     <= '0;
      lvl1     <= '0;
      lvl2     <= '0;
      ch_warm  <= '0;
      ch_cool  <= '0;
      ch_red   <= '0;
      ch_green <= '0;
      ch_blue  <= '0;
    end else if (step_en) begin
      phase    <= phase_next;
      now_ms   <= now_next;
      mark_ms  <= mark_next;
      wait_ms  <= wait_next;
      lvl0     <= lvl0_next;
      lvl1     <= lvl1_next;
      lvl2     <= lvl2_next;
      ch_warm  <= warm_next;
      ch_cool  <= cool_next;
      ch_red   <= red_next;
      ch_green <= green_next;
      ch_blue  <= blue_next;
      result   <= result_next;
    end
  end

endmodule

// ===== hdl/tv_flicker_light_effect.sv =====
// An item passes the input register, then the result register.
// Throughput: one item per cycle unless a held result is not yet taken;
// the whole phase step is one pass of logic.
// Reset (rst, synchronous): phase 0, timers, stage and channel levels cleared;
// brightness 100, speed 100, repeat on; no item or result held.
`include "tv_flicker_light_effect_assert.svh"

module tv_flicker_light_effect #(
  parameter int unsigned TIMER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tvfl_pkg::PCT_BITS-1:0] cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  tvfl_pkg::tvfl_in_t            item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output tvfl_pkg::tvfl_out_t           result
);
  import tvfl_pkg::*;

  tvfl_cfg_t cfg;
  tvfl_in_t  item_q;
  logic      item_q_valid;
  logic      step_en;

  // Advance the held item when the result register is free or being taken
  assign step_en    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || step_en;

  // Input register and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        item_q_valid <= item_valid;
      end
      if (step_en) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Capture the payload on transfer
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  tvfl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tvfl_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (item_q),
    .cfg     (cfg),
    .result  (result)
  );

  `TVFL_ASSERT_NEXT(a_step_gives_result, clk, rst, step_en, result_valid, "step without result")
  `TVFL_ASSERT_SAME(a_stall_cause, clk, rst, !item_ready,
    item_q_valid && result_valid && !result_ready, "input stalled without cause")
  `TVFL_ASSERT_NEXT(a_restart_clears, clk, rst, step_en && item_q.restart && !cfg.halt,
    result.level_warm == '0 && result.level_cool == '0 && result.level_red == '0 &&
    result.level_green == '0 && result.level_blue == '0, "restart left a channel lit")
  `TVFL_ASSERT_NEXT(a_halt_holds, clk, rst, step_en && cfg.halt, !result.changed,
    "levels changed while halted")

endmodule
